// File: hw/rtl/trx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trx_pkg: shared types and constants of the tile raster engine
// Buffer geometry, fixed-point format, request codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package trx_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int FRAC_BITS  = 16;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int HB    = $clog2(MAX_HEIGHT + 1);

	localparam int CW    = 18;                 // clipped loop coordinates
	localparam int PW    = 20;                 // plot coordinates
	localparam int PXW   = PW + FRAC_BITS;     // line position, fixed point
	localparam int LCW   = 17;                 // line point count
	localparam int QW    = FRAC_BITS + 1;      // line step magnitude
	localparam int DSW   = $clog2(FRAC_BITS + 1);
	localparam int SQW   = 32;                 // root operand
	localparam int RSW   = 4;                  // root step counter

	localparam int TILE_W = 32;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 32;

	localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_BLANK  = 2'd2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] plot_t;

	typedef enum logic [2:0] {
		REQ_POINT   = 3'd0,
		REQ_LINE    = 3'd1,
		REQ_OUTLINE = 3'd2,
		REQ_FILL    = 3'd3,
		REQ_CIRCLE  = 3'd4,
		REQ_CLEAR   = 3'd5,
		REQ_READ    = 3'd6,
		REQ_NOP     = 3'd7
	} req_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_WIPE,
		ACT_SETUP,
		ACT_POINT,
		ACT_DIV,
		ACT_LINE,
		ACT_OUT_H,
		ACT_OUT_V,
		ACT_FILL,
		ACT_SQ,
		ACT_RINIT,
		ACT_ROOT,
		ACT_ARC,
		ACT_READ,
		ACT_RESULT
	} act_t;

	typedef struct packed {
		logic load;
		act_t act;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic wipe_last;
		logic div_last;
		logic line_last;
		logic h_empty;
		logic h_last;
		logic v_empty;
		logic v_last;
		logic fill_empty;
		logic fill_last;
		logic circ_empty;
		logic root_last;
		logic arc_last;
		logic k_last;
	} sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/trx_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trx_ifs: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface trx_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  req_type;
	logic signed [15:0] x_first;
	logic signed [15:0] y_first;
	logic signed [15:0] x_second;
	logic signed [15:0] y_second;
	logic signed [15:0] radius;
	logic        [15:0] tile_char;
	logic signed [15:0] tile_attr;

	modport source (output valid, req_type, x_first, y_first, x_second, y_second,
		radius, tile_char, tile_attr, input ready);
	modport sink (input valid, req_type, x_first, y_first, x_second, y_second,
		radius, tile_char, tile_attr, output ready);
endinterface

interface trx_rsp_if;
	logic               valid;
	logic               ready;
	logic        [15:0] read_char;
	logic signed [15:0] read_attr;
	logic               in_bounds;

	modport source (output valid, read_char, read_attr, in_bounds, input ready);
	modport sink (input valid, read_char, read_attr, in_bounds, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/trx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trx_ctrl: request sequencer
// Walks each request through its datapath steps and owns both handshakes.
// ----------------------------------------------------------------------------
module trx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output trx_pkg::cmd_t cmd,
	input  trx_pkg::sts_t sts
);
	import trx_pkg::*;

	typedef enum logic [14:0] {
		ST_WIPE  = 15'b000000000000001,
		ST_IDLE  = 15'b000000000000010,
		ST_SETUP = 15'b000000000000100,
		ST_POINT = 15'b000000000001000,
		ST_DIV   = 15'b000000000010000,
		ST_LINE  = 15'b000000000100000,
		ST_OUT_H = 15'b000000001000000,
		ST_OUT_V = 15'b000000010000000,
		ST_FILL  = 15'b000000100000000,
		ST_SQ    = 15'b000001000000000,
		ST_RINIT = 15'b000010000000000,
		ST_ROOT  = 15'b000100000000000,
		ST_ARC   = 15'b001000000000000,
		ST_READ  = 15'b010000000000000,
		ST_DONE  = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q;
	logic   push;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.act  = ACT_NONE;
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			ST_WIPE: begin
				cmd.act = ACT_WIPE;
				if (sts.wipe_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.act = ACT_SETUP;
				case (sts.req)
					REQ_POINT:   state_d = ST_POINT;
					REQ_LINE:    state_d = ST_DIV;
					REQ_OUTLINE: state_d = ST_OUT_H;
					REQ_FILL:    state_d = ST_FILL;
					REQ_CLEAR:   state_d = ST_FILL;
					REQ_CIRCLE:  state_d = ST_SQ;
					REQ_READ:    state_d = ST_READ;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_POINT: begin
				cmd.act = ACT_POINT;
				state_d = ST_DONE;
			end
			ST_DIV: begin
				cmd.act = ACT_DIV;
				if (sts.div_last) state_d = ST_LINE;
			end
			ST_LINE: begin
				cmd.act = ACT_LINE;
				if (sts.line_last) state_d = ST_DONE;
			end
			ST_OUT_H: begin
				if (sts.h_empty) begin
					state_d = ST_OUT_V;
				end else begin
					cmd.act = ACT_OUT_H;
					if (sts.h_last) state_d = ST_OUT_V;
				end
			end
			ST_OUT_V: begin
				if (sts.v_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.act = ACT_OUT_V;
					if (sts.v_last) state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				if (sts.fill_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.act = ACT_FILL;
					if (sts.fill_last) state_d = ST_DONE;
				end
			end
			ST_SQ: begin
				if (sts.circ_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.act = ACT_SQ;
					state_d = ST_RINIT;
				end
			end
			ST_RINIT: begin
				cmd.act = ACT_RINIT;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.act = ACT_ROOT;
				if (sts.root_last) state_d = ST_ARC;
			end
			ST_ARC: begin
				cmd.act = ACT_ARC;
				if (sts.arc_last) state_d = sts.k_last ? ST_DONE : ST_SQ;
			end
			ST_READ: begin
				cmd.act = ACT_READ;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ovalid_q || out_ready) begin
					cmd.act = ACT_RESULT;
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WIPE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;

`ifndef ASSERT_OFF
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SETUP))
		else $error("accepted beat did not start setup");
	a_push_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");
	a_wipe_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WIPE) |-> (!ovalid_q && !in_ready))
		else $error("handshake active during clearing pass");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ovalid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result slot overwritten while stalled");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/trx_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trx_dp: tile raster datapath
// Tile store, plot/clip unit, line step divider, circle root unit, loop
// counters, configuration registers and result register.
// ----------------------------------------------------------------------------
module trx_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [trx_pkg::CFG_IW-1:0]    cfg_idx,
	input  logic [trx_pkg::CFG_DW-1:0]    cfg_data,
	input  logic [2:0]                    req_type,
	input  logic signed [15:0]            x_first,
	input  logic signed [15:0]            y_first,
	input  logic signed [15:0]            x_second,
	input  logic signed [15:0]            y_second,
	input  logic signed [15:0]            radius,
	input  logic [15:0]                   tile_char,
	input  logic signed [15:0]            tile_attr,
	input  trx_pkg::cmd_t                 cmd,
	output trx_pkg::sts_t                 sts,
	output logic [15:0]                   read_char,
	output logic signed [15:0]            read_attr,
	output logic                          in_bounds
);
	import trx_pkg::*;

	// configuration
	logic [7:0]        width_q;
	logic [6:0]        height_q;
	logic [TILE_W-1:0] blank_q;
	logic [AW-1:0]     wcnt_q;

	// request
	req_t               req_q;
	logic signed [15:0] x1_q, y1_q, x2_q, y2_q, r_q;
	logic [TILE_W-1:0]  tile_q;

	// loops
	coord_t     a_lo_q, a_hi_q, b_lo_q, b_hi_q, cnt_a_q, cnt_b_q;
	logic       ph_q;
	logic [2:0] ph3_q;

	// line
	logic signed [PXW-1:0] px_q, py_q;
	logic                  sx_q, sy_q;
	logic [LCW-1:0]        n_q, lcnt_q;
	logic [LCW:0]          rx_q, ry_q;
	logic [QW-1:0]         dlx_q, dly_q, qx_q, qy_q;
	logic [DSW-1:0]        dstep_q;

	// circle
	logic [SQW-1:0] rr_q, kk_q, sv_q, sres_q;
	logic [14:0]    k_q;
	logic [RSW-1:0] rstep_q;

	// store and result
	logic [TILE_W-1:0] mem_q [DEPTH];
	logic [TILE_W-1:0] rd_q;
	logic              rd_in_q;
	logic [15:0]       res_char_q;
	logic signed [15:0] res_attr_q;
	logic              res_inb_q;

	logic [WB-1:0] aw;
	logic [HB-1:0] ah;
	coord_t        awc, ahc;

	assign aw  = (32'(width_q) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(width_q);
	assign ah  = (32'(height_q) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(height_q);
	assign awc = coord_t'(aw);
	assign ahc = coord_t'(ah);

	// ---- setup: clipped loop ranges ----
	coord_t x1c, y1c, x2c, y2c, xe, ye;
	coord_t lo_a, hi_a, lo_b, hi_b;

	assign x1c = coord_t'(x1_q);
	assign y1c = coord_t'(y1_q);
	assign x2c = coord_t'(x2_q);
	assign y2c = coord_t'(y2_q);
	assign xe  = x1c + x2c;
	assign ye  = y1c + y2c;

	always_comb begin
		lo_a = '0;
		hi_a = '1;
		lo_b = '0;
		hi_b = '1;
		case (req_q)
			REQ_OUTLINE: begin
				lo_a = (x1c < 0) ? coord_t'(0) : x1c;
				hi_a = (x2c < awc - coord_t'(1)) ? x2c : awc - coord_t'(1);
				lo_b = (y1c < 0) ? coord_t'(0) : y1c;
				hi_b = (y2c < ahc - coord_t'(1)) ? y2c : ahc - coord_t'(1);
			end
			REQ_FILL: begin
				lo_a = (x1c < 0) ? coord_t'(0) : x1c;
				lo_b = (y1c < 0) ? coord_t'(0) : y1c;
				if (x2c > 0 && y2c > 0) begin
					hi_a = ((xe < awc) ? xe : awc) - coord_t'(1);
					hi_b = ((ye < ahc) ? ye : ahc) - coord_t'(1);
				end
			end
			REQ_CLEAR: begin
				hi_a = awc - coord_t'(1);
				hi_b = ahc - coord_t'(1);
			end
			default: begin
				lo_a = '0;
			end
		endcase
	end

	// ---- setup: line lengths ----
	coord_t         dx, dy, lx, ly, ax, ay;
	logic [LCW-1:0] mx, my, nn;

	assign dx = x2c - x1c;
	assign dy = y2c - y1c;
	assign lx = (dx >= 0) ? dx + coord_t'(1) : dx - coord_t'(1);
	assign ly = (dy >= 0) ? dy + coord_t'(1) : dy - coord_t'(1);
	assign ax = (lx < 0) ? -lx : lx;
	assign ay = (ly < 0) ? -ly : ly;
	assign mx = ax[LCW-1:0];
	assign my = ay[LCW-1:0];
	assign nn = (mx > my) ? mx : my;

	// ---- step divider, one quotient bit per cycle on both axes ----
	logic [LCW:0] rxn, ryn;
	logic         gex, gey;

	assign rxn = {rx_q[LCW-1:0], dlx_q[QW-1]};
	assign ryn = {ry_q[LCW-1:0], dly_q[QW-1]};
	assign gex = rxn >= {1'b0, n_q};
	assign gey = ryn >= {1'b0, n_q};

	logic signed [PXW-1:0] stx, sty;

	assign stx = sx_q ? -PXW'(qx_q) : PXW'(qx_q);
	assign sty = sy_q ? -PXW'(qy_q) : PXW'(qy_q);

	// truncate toward zero
	plot_t lxi, lyi;

	assign lxi = plot_t'(px_q >>> FRAC_BITS)
		+ plot_t'(px_q[PXW-1] && (px_q[FRAC_BITS-1:0] != '0));
	assign lyi = plot_t'(py_q >>> FRAC_BITS)
		+ plot_t'(py_q[PXW-1] && (py_q[FRAC_BITS-1:0] != '0));

	// ---- root unit, two operand bits per cycle ----
	logic [SQW-1:0] bitv, trial;

	assign bitv  = 32'h4000_0000 >> {rstep_q, 1'b0};
	assign trial = sres_q + bitv;

	// ---- circle points ----
	logic [15:0] uu, vv;
	plot_t       cxp, cyp, cu, cv;

	assign uu  = ph3_q[2] ? sres_q[15:0] : {1'b0, k_q};
	assign vv  = ph3_q[2] ? {1'b0, k_q} : sres_q[15:0];
	assign cxp = plot_t'(x1_q);
	assign cyp = plot_t'(y1_q);
	assign cu  = (ph3_q[1] ^ ph3_q[0]) ? cxp - plot_t'(uu) : cxp + plot_t'(uu);
	assign cv  = ph3_q[1] ? cyp - plot_t'(vv) : cyp + plot_t'(vv);

	// ---- plot and clip ----
	logic          pen, inb, mem_we;
	plot_t         ppx, ppy;
	logic [AW-1:0] paddr, waddr;
	logic [TILE_W-1:0] wdata;

	always_comb begin
		pen = 1'b0;
		ppx = cxp;
		ppy = cyp;
		case (cmd.act)
			ACT_POINT: pen = 1'b1;
			ACT_LINE: begin
				pen = 1'b1;
				ppx = lxi;
				ppy = lyi;
			end
			ACT_OUT_H: begin
				pen = 1'b1;
				ppx = plot_t'(cnt_a_q);
				ppy = ph_q ? plot_t'(y2_q) : cyp;
			end
			ACT_OUT_V: begin
				pen = 1'b1;
				ppx = ph_q ? plot_t'(x2_q) : cxp;
				ppy = plot_t'(cnt_b_q);
			end
			ACT_FILL: begin
				pen = 1'b1;
				ppx = plot_t'(cnt_a_q);
				ppy = plot_t'(cnt_b_q);
			end
			ACT_ARC: begin
				pen = 1'b1;
				ppx = cu;
				ppy = cv;
			end
			default: pen = 1'b0;
		endcase
	end

	assign inb = (ppx >= 0) && (ppx < plot_t'(aw)) && (ppy >= 0) && (ppy < plot_t'(ah));
	assign paddr = AW'(ppx[WB-1:0]) + AW'(ppy[HB-1:0]) * AW'(aw);

	assign mem_we = (cmd.act == ACT_WIPE) || (pen && inb);
	assign waddr  = (cmd.act == ACT_WIPE) ? wcnt_q : paddr;
	assign wdata  = (cmd.act == ACT_WIPE) ? '0 : tile_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wdata;
		if (cmd.act == ACT_READ) rd_q <= mem_q[paddr];
	end

	// ---- configuration and clearing pass ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			blank_q  <= '0;
			wcnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_WIDTH:  width_q  <= cfg_data[7:0];
					CFG_HEIGHT: height_q <= cfg_data[6:0];
					CFG_BLANK:  blank_q  <= cfg_data[TILE_W-1:0];
					default:    width_q  <= width_q;
				endcase
			end
			if (cmd.act == ACT_WIPE) wcnt_q <= wcnt_q + AW'(1);
		end
	end

	// ---- working registers ----
	logic [TILE_W-1:0] rdv;

	assign rdv = rd_in_q ? rd_q : blank_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_t'(req_type);
			x1_q   <= x_first;
			y1_q   <= y_first;
			x2_q   <= x_second;
			y2_q   <= y_second;
			r_q    <= radius;
			tile_q <= (req_t'(req_type) == REQ_CLEAR) ? blank_q : {tile_attr, tile_char};
		end
		case (cmd.act)
			ACT_SETUP: begin
				a_lo_q  <= lo_a;
				a_hi_q  <= hi_a;
				b_lo_q  <= lo_b;
				b_hi_q  <= hi_b;
				cnt_a_q <= lo_a;
				cnt_b_q <= lo_b;
				ph_q    <= 1'b0;
				ph3_q   <= '0;
				px_q    <= PXW'(x1_q) <<< FRAC_BITS;
				py_q    <= PXW'(y1_q) <<< FRAC_BITS;
				sx_q    <= lx < 0;
				sy_q    <= ly < 0;
				n_q     <= nn;
				lcnt_q  <= nn;
				rx_q    <= {2'b00, mx[LCW-1:1]};
				ry_q    <= {2'b00, my[LCW-1:1]};
				dlx_q   <= {mx[0], {FRAC_BITS{1'b0}}};
				dly_q   <= {my[0], {FRAC_BITS{1'b0}}};
				qx_q    <= '0;
				qy_q    <= '0;
				dstep_q <= '0;
				rr_q    <= SQW'(r_q[14:0]) * SQW'(r_q[14:0]);
				k_q     <= '0;
			end
			ACT_DIV: begin
				rx_q    <= gex ? rxn - {1'b0, n_q} : rxn;
				ry_q    <= gey ? ryn - {1'b0, n_q} : ryn;
				qx_q    <= {qx_q[QW-2:0], gex};
				qy_q    <= {qy_q[QW-2:0], gey};
				dlx_q   <= dlx_q << 1;
				dly_q   <= dly_q << 1;
				dstep_q <= dstep_q + DSW'(1);
			end
			ACT_LINE: begin
				px_q   <= px_q + stx;
				py_q   <= py_q + sty;
				lcnt_q <= lcnt_q - LCW'(1);
			end
			ACT_OUT_H: begin
				ph_q <= ~ph_q;
				if (ph_q) cnt_a_q <= cnt_a_q + coord_t'(1);
			end
			ACT_OUT_V: begin
				ph_q <= ~ph_q;
				if (ph_q) cnt_b_q <= cnt_b_q + coord_t'(1);
			end
			ACT_FILL: begin
				if (cnt_a_q == a_hi_q) begin
					cnt_a_q <= a_lo_q;
					cnt_b_q <= cnt_b_q + coord_t'(1);
				end else begin
					cnt_a_q <= cnt_a_q + coord_t'(1);
				end
			end
			ACT_SQ: kk_q <= SQW'(k_q) * SQW'(k_q);
			ACT_RINIT: begin
				sv_q    <= rr_q - kk_q;
				sres_q  <= '0;
				rstep_q <= '0;
			end
			ACT_ROOT: begin
				if (sv_q >= trial) begin
					sv_q   <= sv_q - trial;
					sres_q <= (sres_q >> 1) + bitv;
				end else begin
					sres_q <= sres_q >> 1;
				end
				rstep_q <= rstep_q + RSW'(1);
			end
			ACT_ARC: begin
				ph3_q <= ph3_q + 3'd1;
				if (ph3_q == 3'd7) k_q <= k_q + 15'd1;
			end
			ACT_READ: rd_in_q <= inb;
			ACT_RESULT: begin
				if (req_q == REQ_READ) begin
					res_char_q <= rdv[15:0];
					res_attr_q <= rdv[31:16];
					res_inb_q  <= rd_in_q;
				end else begin
					res_char_q <= '0;
					res_attr_q <= '0;
					res_inb_q  <= 1'b0;
				end
			end
			default: ph_q <= ph_q;
		endcase
	end

	// ---- status ----
	assign sts.req        = req_q;
	assign sts.wipe_last  = wcnt_q == AW'(DEPTH - 1);
	assign sts.div_last   = dstep_q == DSW'(FRAC_BITS);
	assign sts.line_last  = lcnt_q == LCW'(1);
	assign sts.h_empty    = a_lo_q > a_hi_q;
	assign sts.h_last     = ph_q && (cnt_a_q == a_hi_q);
	assign sts.v_empty    = b_lo_q > b_hi_q;
	assign sts.v_last     = ph_q && (cnt_b_q == b_hi_q);
	assign sts.fill_empty = (a_lo_q > a_hi_q) || (b_lo_q > b_hi_q);
	assign sts.fill_last  = (cnt_a_q == a_hi_q) && (cnt_b_q == b_hi_q);
	assign sts.circ_empty = r_q < 0;
	assign sts.root_last  = rstep_q == '1;
	assign sts.arc_last   = ph3_q == 3'd7;
	assign sts.k_last     = k_q == r_q[14:0];

	assign read_char = res_char_q;
	assign read_attr = res_attr_q;
	assign in_bounds = res_inb_q;

endmodule
`default_nettype wire

// File: hw/rtl/tile_raster_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_raster_engine: tile buffer with point, line, rectangle, circle,
// clear and read requests
// Requests arrive as beats on req; every request returns one beat on rsp.
// Configuration (width, height, blank tile) is written on the cfg port; the
// user must write it only while the engine is idle; it is not enforced.
// Timing: after reset the store is swept to zero, one tile per cycle,
// with req.ready low; config writes are taken meanwhile. Each request then
// runs alone, with at most one store write per cycle:
//   point / read       a single store write or read
//   line               divider, then n points, n = longer axis length
//   outline            each clipped column and row plotted twice
//   fill / clear       each clipped tile written once
//   circle             eight arc points per radius step, (r+1) steps
// The line divider and root unit add overheads; store write port sets the
// rest. The result sits in an output register; a stalled rsp holds it and
// the next request is accepted meanwhile, waiting only at its own result.
// ----------------------------------------------------------------------------
module tile_raster_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	trx_req_if.sink                       req,
	trx_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [trx_pkg::CFG_IW-1:0]    cfg_idx,
	input  logic [trx_pkg::CFG_DW-1:0]    cfg_data
);
	import trx_pkg::*;

	cmd_t cmd;   // controller to datapath
	sts_t sts;   // datapath flags back

	// sequencer: handshakes and request steps
	trx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store, arithmetic units and result register
	trx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.req_type  (req.req_type),
		.x_first   (req.x_first),
		.y_first   (req.y_first),
		.x_second  (req.x_second),
		.y_second  (req.y_second),
		.radius    (req.radius),
		.tile_char (req.tile_char),
		.tile_attr (req.tile_attr),
		.cmd       (cmd),
		.sts       (sts),
		.read_char (rsp.read_char),
		.read_attr (rsp.read_attr),
		.in_bounds (rsp.in_bounds)
	);

endmodule
`default_nettype wire
